// ----- src/pre_pkg.sv -----
// ============================================================================
// pre_pkg: shared types and constants of the printable run extractor
// Payload structs, the command word passed from front to back, the prefix
// write port and the fixed widths and codes of the design.
// ============================================================================
package pre_pkg;

   localparam int PRE_MIN_LIMIT = 32;
   localparam int PRE_MAX_RUN   = 65536;

   localparam int OFF_W = 48;
   localparam int CSR_W = 6;
   localparam int MIN_W = 7;
   localparam int CNT_W = 6;

   localparam logic [CSR_W-1:0] MIN_LENGTH_RESET = CSR_W'(4);

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   localparam logic [1:0] CMD_CHAR   = 2'd0;
   localparam logic [1:0] CMD_END    = 2'd1;
   localparam logic [1:0] CMD_REPLAY = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]       char_out;
      logic             char_valid;
      logic             string_end;
      logic [OFF_W-1:0] start_offset;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       data_byte;
      logic [CNT_W-1:0] count;
      logic [OFF_W-1:0] start_offset;
   } cmd_type;

   typedef struct packed {
      logic             en;
      logic [CNT_W-1:0] addr;
      logic [7:0]       data;
   } pfx_wr_type;

endpackage

// ----- src/pre_front.sv -----
// ============================================================================
// pre_front: input acceptance and run tracking
// Accepts bytes, tracks the current printable run and the byte offset,
// writes the prefix bytes and issues at most one command per transaction.
// ============================================================================
module pre_front
   import pre_pkg::*;
#(
   parameter int MIN_LIMIT = PRE_MIN_LIMIT,
   parameter int MAX_RUN   = PRE_MAX_RUN
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_payload_type  req_payload,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic             fifo_full,
   input  logic             replay_done,
   output logic             cmd_push,
   output cmd_type          cmd,
   output pfx_wr_type       pfx_wr
);

   localparam int RUN_W = $clog2(MAX_RUN + 1);

   logic [CSR_W-1:0] min_length_ff;
   logic [RUN_W-1:0] run_length_ff, run_length_in;
   logic [OFF_W-1:0] run_start_ff, run_start_in;
   logic [OFF_W-1:0] byte_offset_ff, byte_offset_in;
   logic             replay_pending_ff, replay_pending_in;

   logic             accept;
   logic             printable;
   logic [MIN_W-1:0] eff_min;
   logic [RUN_W-1:0] mn_ext;
   logic [RUN_W-1:0] len;
   logic [OFF_W-1:0] start;
   logic             reported;

   always_comb begin
      if (min_length_ff == '0) begin
         eff_min = MIN_W'(1);
      end else if ({1'b0, min_length_ff} > MIN_W'(MIN_LIMIT)) begin
         eff_min = MIN_W'(MIN_LIMIT);
      end else begin
         eff_min = {1'b0, min_length_ff};
      end
   end

   assign mn_ext    = RUN_W'(eff_min);
   assign req_stall = fifo_full | replay_pending_ff;
   assign accept    = req_valid & ~req_stall;
   assign printable = ((req_payload.data_byte >= CHAR_SPACE) &&
                       (req_payload.data_byte <= CHAR_TILDE)) ||
                      (req_payload.data_byte == CHAR_TAB);
   assign len       = run_length_ff + RUN_W'(1);
   assign start     = (run_length_ff == '0) ? byte_offset_ff : run_start_ff;
   assign reported  = (run_length_ff != '0) && (run_length_ff >= mn_ext);

   always_comb begin
      run_length_in     = run_length_ff;
      run_start_in      = run_start_ff;
      byte_offset_in    = byte_offset_ff;
      replay_pending_in = replay_pending_ff & ~replay_done;
      cmd_push          = 1'b0;
      cmd.kind          = CMD_CHAR;
      cmd.data_byte     = req_payload.data_byte;
      cmd.count         = CNT_W'(eff_min - MIN_W'(1));
      cmd.start_offset  = run_start_ff;
      pfx_wr.en         = 1'b0;
      pfx_wr.addr       = CNT_W'(run_length_ff);
      pfx_wr.data       = req_payload.data_byte;
      if (accept) begin
         priority if (req_payload.end_of_input) begin
            cmd_push       = reported;
            cmd.kind       = CMD_END;
            run_length_in  = '0;
            run_start_in   = '0;
            byte_offset_in = '0;
         end else if (printable) begin
            run_start_in     = start;
            cmd.start_offset = start;
            byte_offset_in   = byte_offset_ff + OFF_W'(1);
            if (run_length_ff < RUN_W'(MAX_RUN)) begin
               run_length_in = len;
               pfx_wr.en     = run_length_ff < RUN_W'(MIN_LIMIT - 1);
               if (len == mn_ext) begin
                  cmd_push          = 1'b1;
                  cmd.kind          = CMD_REPLAY;
                  replay_pending_in = 1'b1;
               end else if (len > mn_ext) begin
                  cmd_push = 1'b1;
                  cmd.kind = CMD_CHAR;
               end
            end
         end else begin
            cmd_push       = reported;
            cmd.kind       = CMD_END;
            run_length_in  = '0;
            byte_offset_in = byte_offset_ff + OFF_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff     <= MIN_LENGTH_RESET;
         run_length_ff     <= '0;
         run_start_ff      <= '0;
         byte_offset_ff    <= '0;
         replay_pending_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            min_length_ff <= csr_wdata;
         end
         run_length_ff     <= run_length_in;
         run_start_ff      <= run_start_in;
         byte_offset_ff    <= byte_offset_in;
         replay_pending_ff <= replay_pending_in;
      end
   end

endmodule

// ----- src/pre_cmd_fifo.sv -----
// ============================================================================
// pre_cmd_fifo: two-entry command queue
// Decouples the front from the back so that each side stalls on its own.
// ============================================================================
module pre_cmd_fifo
   import pre_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push;
   logic        do_pop;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/pre_back.sv -----
// ============================================================================
// pre_back: command execution and result register
// Holds the prefix memory, replays held bytes, and drives the result
// register toward the receiver.
// ============================================================================
module pre_back
   import pre_pkg::*;
#(
   parameter int MIN_LIMIT = PRE_MIN_LIMIT
) (
   input  logic            clock,
   input  logic            reset,
   input  pfx_wr_type      pfx_wr,
   input  cmd_type         head,
   input  logic            fifo_empty,
   output logic            pop,
   output logic            replay_done,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int DEPTH = MIN_LIMIT - 1;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_LAST  = 2'd3;

   logic [7:0]       mem [DEPTH];
   logic [7:0]       rd_data_ff;
   logic             rd_en;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       byte_ff, byte_in;
   logic [OFF_W-1:0] off_ff, off_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   logic             out_free;
   logic             load;
   logic [CNT_W-1:0] idx_next;

   assign out_free    = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign idx_next    = idx_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (pfx_wr.en) begin
         mem[pfx_wr.addr[IDX_W-1:0]] <= pfx_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[idx_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      byte_in        = byte_ff;
      off_in         = off_ff;
      pop            = 1'b0;
      replay_done    = 1'b0;
      rd_en          = 1'b0;
      load           = 1'b0;
      rsp_payload_in = rsp_payload_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               unique case (head.kind)
                  CMD_CHAR: begin
                     if (out_free) begin
                        pop            = 1'b1;
                        load           = 1'b1;
                        rsp_payload_in = {head.data_byte, 1'b1, 1'b0, head.start_offset};
                     end
                  end
                  CMD_END: begin
                     if (out_free) begin
                        pop            = 1'b1;
                        load           = 1'b1;
                        rsp_payload_in = {8'h00, 1'b0, 1'b1, head.start_offset};
                     end
                  end
                  CMD_REPLAY: begin
                     pop      = 1'b1;
                     idx_in   = '0;
                     count_in = head.count;
                     byte_in  = head.data_byte;
                     off_in   = head.start_offset;
                     state_in = (head.count != '0) ? ST_FETCH : ST_LAST;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (out_free) begin
               load           = 1'b1;
               rsp_payload_in = {rd_data_ff, 1'b1, 1'b0, off_ff};
               idx_in         = idx_next;
               state_in       = (idx_next == count_ff) ? ST_LAST : ST_FETCH;
            end
         end
         ST_LAST: begin
            if (out_free) begin
               load           = 1'b1;
               replay_done    = 1'b1;
               rsp_payload_in = {byte_ff, 1'b1, 1'b0, off_ff};
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      count_ff       <= count_in;
      byte_ff        <= byte_in;
      off_ff         <= off_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/printable_run_extractor.sv -----
// ============================================================================
// printable_run_extractor: streaming printable string extraction
// Reports runs of printable bytes as characters and end markers.
// ============================================================================
// Usage:
//   req channel: one byte or an end-of-input flag per transaction
//   (req_valid / req_stall). rsp channel: one string character or one end
//   marker per transaction, tagged with the run's start offset.
//   csr_we / csr_wdata write min_length; write it only while idle.
// Throughput and timing:
//   A byte that passes straight through is registered in the command queue
//   and then in the rsp register. The front takes one byte per cycle while
//   the two-entry command queue has room and no replay is pending; the back
//   drains one plain result per cycle while the receiver does not stall.
//   When a run reaches min_length the back replays the held prefix from its
//   memory, one read and one load per byte, while req_stall stays high.
// Reset:
//   Synchronous, active high. Clears the run, the offset and both
//   channels; min_length returns to 4. Prefix memory is not cleared.
// Receiver stall:
//   rsp holds its transaction; the queue fills and then req_stall rises.
// ============================================================================
module printable_run_extractor
   import pre_pkg::*;
#(
   parameter int MIN_LIMIT = PRE_MIN_LIMIT,
   parameter int MAX_RUN   = PRE_MAX_RUN
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_payload_type  req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_payload_type  rsp_payload,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);

   logic       cmd_push;
   cmd_type    cmd;
   cmd_type    head;
   pfx_wr_type pfx_wr;
   logic       fifo_full;
   logic       fifo_empty;
   logic       pop;
   logic       replay_done;

   pre_front #(
      .MIN_LIMIT (MIN_LIMIT),
      .MAX_RUN   (MAX_RUN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .fifo_full   (fifo_full),
      .replay_done (replay_done),
      .cmd_push    (cmd_push),
      .cmd         (cmd),
      .pfx_wr      (pfx_wr)
   );

   pre_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (pop),
      .head     (head),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   pre_back #(
      .MIN_LIMIT (MIN_LIMIT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pfx_wr      (pfx_wr),
      .head        (head),
      .fifo_empty  (fifo_empty),
      .pop         (pop),
      .replay_done (replay_done),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
